// ===== hw/rtl/crfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crfr_pkg
// Shared types and constants for the command frame receiver.
// ----------------------------------------------------------------------------
package crfr_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LengthWidth = 16;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDatWidth = 16;

   localparam logic [ByteWidth-1:0]   SumComplement = 8'hFF;
   localparam logic [ByteWidth-1:0]   CommandLimit  = 8'h10;
   localparam logic [LengthWidth-1:0] MinLength     = 16'd4;

   localparam logic [ByteWidth-1:0]   SyncReset  = 8'd126;
   localparam logic [ByteWidth-1:0]   AddrReset  = 8'd1;
   localparam logic [LengthWidth-1:0] LimitReset = 16'd256;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SYNC_VALUE   = 2'd0,
      CSR_NODE_ADDRESS = 2'd1,
      CSR_LENGTH_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_HUNT   = 2'd0,
      PHASE_LEN_HI = 2'd1,
      PHASE_LEN_LO = 2'd2,
      PHASE_BODY   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_BAD_SUM    = 3'd1,
      STATUS_OTHER_ADDR = 3'd2,
      STATUS_CMD_BIG    = 3'd3,
      STATUS_BAD_LENGTH = 3'd4
   } frame_status_type;

   typedef struct packed {
      logic [ByteWidth-1:0]   sync_value;
      logic [ByteWidth-1:0]   node_address;
      logic [LengthWidth-1:0] length_limit;
   } cfg_type;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 body_valid;
      logic                 frame_done;
      frame_status_type     frame_status;
   } result_type;

endpackage

// ===== hw/rtl/command_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// command_frame_receiver_core
// Byte-stream frame receiver: sync, 16-bit length, checked body.
// ----------------------------------------------------------------------------
// Every received byte gives exactly one output beat that echoes it, with
// body_valid on body bytes other than the checksum and tlast on the byte that
// ends or rejects a frame, where tuser carries the frame status. A byte passes
// an input register, the parser logic and the result register, which loads
// it when empty or being taken. One byte can be taken in every cycle while
// the result side does not stall. The user must write registers over the csr
// port only while no beat is in flight; the block does not enforce it.
// csr_ready is always high; the parser step between the registers is combinational.
module command_frame_receiver_core
   import crfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] rx_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] out_byte
   output logic                   rsp_tlast,   // frame_done
   output logic [3:0]             rsp_tuser,   // [0] body_valid, [3:1] frame_status
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrDatWidth-1:0] csr_data
);

   cfg_type              cfg_ff;
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 advance;
   logic                 out_valid;
   result_type           parse_result;
   result_type           out_result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value   <= SyncReset;
         cfg_ff.node_address <= AddrReset;
         cfg_ff.length_limit <= LimitReset;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SYNC_VALUE:   cfg_ff.sync_value   <= csr_data[ByteWidth-1:0];
            CSR_NODE_ADDRESS: cfg_ff.node_address <= csr_data[ByteWidth-1:0];
            CSR_LENGTH_LIMIT: cfg_ff.length_limit <= csr_data[LengthWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance    = in_valid_ff && (!out_valid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   crfr_frame_fsm u_frame_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (parse_result)
   );

   crfr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result_in  (parse_result),
      .take       (rsp_tready),
      .valid      (out_valid),
      .result_out (out_result)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = out_result.out_byte;
   assign rsp_tlast  = out_result.frame_done;
   assign rsp_tuser  = {out_result.frame_status, out_result.body_valid};

endmodule

// ===== hw/rtl/crfr_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// crfr_frame_fsm
// Frame parser: sync hunt, length capture, body sum and frame checks.
// ----------------------------------------------------------------------------
module crfr_frame_fsm
   import crfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [ByteWidth-1:0] rx_byte,
   input  cfg_type              cfg,
   output result_type           result
);

   phase_type              phase_ff, phase_in;
   logic [LengthWidth-1:0] body_length_ff, body_length_in;
   logic [LengthWidth-1:0] bytes_seen_ff, bytes_seen_in;
   logic [ByteWidth-1:0]   running_sum_ff, running_sum_in;
   logic [ByteWidth-1:0]   dest_byte_ff, dest_byte_in;
   logic [ByteWidth-1:0]   command_byte_ff, command_byte_in;

   logic [LengthWidth-1:0] length_full;
   logic [LengthWidth:0]   seen_next;
   logic [ByteWidth-1:0]   dest_use;
   logic [ByteWidth-1:0]   cmd_use;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_HUNT;
         body_length_ff  <= '0;
         bytes_seen_ff   <= '0;
         running_sum_ff  <= '0;
         dest_byte_ff    <= '0;
         command_byte_ff <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         body_length_ff  <= body_length_in;
         bytes_seen_ff   <= bytes_seen_in;
         running_sum_ff  <= running_sum_in;
         dest_byte_ff    <= dest_byte_in;
         command_byte_ff <= command_byte_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      body_length_in  = body_length_ff;
      bytes_seen_in   = bytes_seen_ff;
      running_sum_in  = running_sum_ff;
      dest_byte_in    = dest_byte_ff;
      command_byte_in = command_byte_ff;

      length_full = {body_length_ff[LengthWidth-1:ByteWidth], rx_byte};
      seen_next   = {1'b0, bytes_seen_ff} + {{LengthWidth{1'b0}}, 1'b1};
      dest_use    = (bytes_seen_ff == 16'd2) ? rx_byte : dest_byte_ff;
      cmd_use     = (bytes_seen_ff == 16'd3) ? rx_byte : command_byte_ff;

      result.out_byte     = rx_byte;
      result.body_valid   = 1'b0;
      result.frame_done   = 1'b0;
      result.frame_status = STATUS_OK;

      case (phase_ff)
         PHASE_HUNT: begin
            if (rx_byte == cfg.sync_value) begin
               phase_in = PHASE_LEN_HI;
            end
         end
         PHASE_LEN_HI: begin
            body_length_in = {rx_byte, {ByteWidth{1'b0}}};
            phase_in       = PHASE_LEN_LO;
         end
         PHASE_LEN_LO: begin
            body_length_in = length_full;
            if (length_full < MinLength || length_full >= cfg.length_limit) begin
               result.frame_done   = 1'b1;
               result.frame_status = STATUS_BAD_LENGTH;
               phase_in            = PHASE_HUNT;
            end else begin
               bytes_seen_in  = '0;
               running_sum_in = '0;
               phase_in       = PHASE_BODY;
            end
         end
         PHASE_BODY: begin
            dest_byte_in    = dest_use;
            command_byte_in = cmd_use;
            bytes_seen_in   = seen_next[LengthWidth-1:0];
            if (seen_next >= {1'b0, body_length_ff}) begin
               result.frame_done = 1'b1;
               phase_in          = PHASE_HUNT;
               if (rx_byte != (SumComplement - running_sum_ff)) begin
                  result.frame_status = STATUS_BAD_SUM;
               end else if (dest_use != cfg.node_address) begin
                  result.frame_status = STATUS_OTHER_ADDR;
               end else if (cmd_use >= CommandLimit) begin
                  result.frame_status = STATUS_CMD_BIG;
               end else begin
                  result.frame_status = STATUS_OK;
               end
            end else begin
               result.body_valid = 1'b1;
               running_sum_in    = running_sum_ff + rx_byte;
            end
         end
         default: begin
            phase_in = PHASE_HUNT;
         end
      endcase
   end

endmodule

// ===== hw/rtl/crfr_out_reg.sv =====
// ----------------------------------------------------------------------------
// crfr_out_reg
// Result register holding one beat for the downstream side.
// ----------------------------------------------------------------------------
module crfr_out_reg
   import crfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result_in,
   input  logic       take,
   output logic       valid,
   output result_type result_out
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign valid      = valid_ff;
   assign result_out = result_ff;

endmodule

// ===== hw/rtl/crfr_checker.sv =====
// ----------------------------------------------------------------------------
// crfr_checker
// Port-level checks on the result beats of the frame receiver.
// ----------------------------------------------------------------------------
module crfr_checker
   import crfr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [3:0] rsp_tuser
);

   // stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // status only on the closing beat
   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser[3:1] == STATUS_OK)
      else $error("status set on a beat that does not end a frame");

   // closing beat is never a plain body byte
   a_last_not_body: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser[0])
      else $error("frame end marked as body byte");

   // status code within the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[3:1] <= STATUS_BAD_LENGTH)
      else $error("undefined frame status");

endmodule

bind command_frame_receiver_core crfr_checker u_crfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
